// File: rtl/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only while out of reset
`define PTSU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define PTSU_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/ptsu_pkg.sv
// shared types and constants of the phase timing statistics unit
package ptsu_pkg;

  localparam int PHASE_SLOTS_DEF   = 32;
  localparam int COUNTER_SLOTS_DEF = 32;

  localparam int OP_W       = 3;
  localparam int SLOT_W     = 6;
  localparam int TIME_W     = 64;
  localparam int IN_DATA_W  = 200;
  localparam int OUT_DATA_W = 320;
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 64;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // configuration register index
  localparam logic [CFG_ADDR_W-1:0] REG_MONITOR_ENABLE = 1'b0;

  typedef enum logic [OP_W-1:0] {
    OP_RECORD       = 3'd0,
    OP_ADD          = 3'd1,
    OP_READ_PHASE   = 3'd2,
    OP_READ_COUNTER = 3'd3,
    OP_CLEAR        = 3'd4
  } op_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic commit;
  } ptsu_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_read;
    logic out_busy;
  } ptsu_stat_t;

endpackage

// File: rtl/phase_timing_stats_unit.sv
// top level of the phase timing statistics unit
// each item is handled in order: the transfer cycle reads the table ram, the execute state
// does the read-modify-write of that row and loads the result register
// a read result is registered when its item commits, then shows on out_tvalid; no new item
// is taken until the current one commits; a read item waits in its execute state while an
// earlier result is still untaken; synchronous active-low reset; per-row valid bits empty both tables at once
module phase_timing_stats_unit import ptsu_pkg::*; #(
  parameter int PHASE_SLOTS   = PHASE_SLOTS_DEF,
  parameter int COUNTER_SLOTS = COUNTER_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // slot_index[5:0], start_time[69:6], end_time[133:70], add_amount[197:134], zero pad
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // operation[2:0]
  input  logic [OP_W-1:0]       in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // total_time[63:0], sample_count[127:64], min_time[191:128], max_time[255:192],
  // event_total[319:256]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  ptsu_cmd_t  cmd;
  ptsu_stat_t stat;

  ptsu_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ptsu_datapath #(
    .PHASE_SLOTS   (PHASE_SLOTS),
    .COUNTER_SLOTS (COUNTER_SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .stat       (stat),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// File: rtl/ptsu_ram.sv
// generic single-write, single-read ram with registered read data
module ptsu_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 32,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/ptsu_ctrl.sv
// controller: accept and execute sequencing
module ptsu_ctrl import ptsu_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  ptsu_stat_t stat,
  output ptsu_cmd_t  cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  // commands
  always_comb begin
    cmd.capture = in_tvalid && in_tready_r;
    cmd.commit  = (state_r == S_EXEC) && !(stat.is_read && stat.out_busy);
  end

  // next state
  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready_nxt = 1'b1;
        if (cmd.capture) begin
          state_nxt     = S_EXEC;
          in_tready_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        if (cmd.commit) begin
          state_nxt     = S_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_tready_nxt = 1'b0;
      end
    endcase
  end

  // state and registered ready
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

endmodule

// File: rtl/ptsu_datapath.sv
// datapath: item capture, table rams, read-modify-write and result register
module ptsu_datapath import ptsu_pkg::*; #(
  parameter int PHASE_SLOTS   = PHASE_SLOTS_DEF,
  parameter int COUNTER_SLOTS = COUNTER_SLOTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  ptsu_cmd_t             cmd,
  output ptsu_stat_t            stat,
  input  logic [OP_W-1:0]       in_tuser,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata
);

  localparam int PA_W  = (PHASE_SLOTS > 1) ? $clog2(PHASE_SLOTS) : 1;
  localparam int CA_W  = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;
  localparam int ROW_W = 4 * TIME_W;

  // input fields
  logic [SLOT_W-1:0] slot;
  logic [TIME_W-1:0] start_t, end_t, amount;
  logic              ph_ok, ct_ok;
  logic [PA_W-1:0]   ph_idx;
  logic [CA_W-1:0]   ct_idx;

  assign slot    = in_tdata[SLOT_W-1:0];
  assign start_t = in_tdata[SLOT_W +: TIME_W];
  assign end_t   = in_tdata[SLOT_W+TIME_W +: TIME_W];
  assign amount  = in_tdata[SLOT_W+2*TIME_W +: TIME_W];
  assign ph_ok   = {1'b0, slot} < (SLOT_W+1)'(PHASE_SLOTS);
  assign ct_ok   = {1'b0, slot} < (SLOT_W+1)'(COUNTER_SLOTS);
  assign ph_idx  = slot[PA_W-1:0];
  assign ct_idx  = slot[CA_W-1:0];

  // row valid bits, a row not valid reads as zero
  logic [PHASE_SLOTS-1:0]   ph_vld_r;
  logic [COUNTER_SLOTS-1:0] ct_vld_r;

  // captured item
  op_t               op_r;
  logic [TIME_W-1:0] elapsed_r, amount_r;
  logic              ph_ok_r, ct_ok_r, start_nz_r, ph_hit_r, ct_hit_r;
  logic [PA_W-1:0]   ph_idx_r;
  logic [CA_W-1:0]   ct_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r       <= op_t'(in_tuser);
      elapsed_r  <= (end_t >= start_t) ? end_t - start_t : '0;
      amount_r   <= amount;
      ph_ok_r    <= ph_ok;
      ct_ok_r    <= ct_ok;
      start_nz_r <= start_t != '0;
      ph_hit_r   <= ph_ok && ph_vld_r[ph_idx];
      ct_hit_r   <= ct_ok && ct_vld_r[ct_idx];
      ph_idx_r   <= ph_idx;
      ct_idx_r   <= ct_idx;
    end
  end

  // configuration
  logic monitor_en_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      monitor_en_r <= 1'b0;
    end else if (cfg_we && cfg_addr == REG_MONITOR_ENABLE) begin
      monitor_en_r <= cfg_wdata[0];
    end
  end

  // operation decode
  logic is_record, is_add, is_rd_ph, is_rd_ct, is_clear;

  always_comb begin
    is_record = 1'b0;
    is_add    = 1'b0;
    is_rd_ph  = 1'b0;
    is_rd_ct  = 1'b0;
    is_clear  = 1'b0;
    unique case (op_r)
      OP_RECORD:       is_record = 1'b1;
      OP_ADD:          is_add    = 1'b1;
      OP_READ_PHASE:   is_rd_ph  = 1'b1;
      OP_READ_COUNTER: is_rd_ct  = 1'b1;
      OP_CLEAR:        is_clear  = 1'b1;
      default:         is_clear  = 1'b0;
    endcase
  end

  // table rams
  logic             ph_we, ct_we;
  logic [ROW_W-1:0] ph_rdata, ph_wdata;
  logic [TIME_W-1:0] ct_rdata, ct_wdata;

  ptsu_ram #(.WIDTH(ROW_W), .DEPTH(PHASE_SLOTS), .ADDR_W(PA_W)) u_phase_ram (
    .clk   (clk),
    .we    (ph_we),
    .waddr (ph_idx_r),
    .wdata (ph_wdata),
    .re    (cmd.capture),
    .raddr (ph_idx),
    .rdata (ph_rdata)
  );

  ptsu_ram #(.WIDTH(TIME_W), .DEPTH(COUNTER_SLOTS), .ADDR_W(CA_W)) u_counter_ram (
    .clk   (clk),
    .we    (ct_we),
    .waddr (ct_idx_r),
    .wdata (ct_wdata),
    .re    (cmd.capture),
    .raddr (ct_idx),
    .rdata (ct_rdata)
  );

  // phase entry update
  logic [ROW_W-1:0]  ph_row;
  logic [TIME_W-1:0] cur_total, cur_count, cur_min, cur_max;
  logic [TIME_W-1:0] new_count, new_min, new_max;

  assign ph_row    = ph_hit_r ? ph_rdata : '0;
  assign cur_total = ph_row[0 +: TIME_W];
  assign cur_count = ph_row[TIME_W +: TIME_W];
  assign cur_min   = ph_row[2*TIME_W +: TIME_W];
  assign cur_max   = ph_row[3*TIME_W +: TIME_W];
  assign new_count = cur_count + TIME_W'(1);
  assign new_min   = (new_count == TIME_W'(1) || elapsed_r < cur_min) ? elapsed_r : cur_min;
  assign new_max   = (elapsed_r > cur_max) ? elapsed_r : cur_max;
  assign ph_wdata  = {new_max, new_min, new_count, cur_total + elapsed_r};
  assign ph_we     = cmd.commit && is_record && monitor_en_r && start_nz_r && ph_ok_r;

  // saturating event counter
  logic [TIME_W-1:0] ct_cur;
  logic [TIME_W:0]   ct_sum;

  assign ct_cur   = ct_hit_r ? ct_rdata : '0;
  assign ct_sum   = {1'b0, ct_cur} + {1'b0, amount_r};
  assign ct_wdata = ct_sum[TIME_W] ? TIME_MAX : ct_sum[TIME_W-1:0];
  assign ct_we    = cmd.commit && is_add && monitor_en_r && ct_ok_r;

  // valid bits: clear drops every row at once
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_vld_r <= '0;
      ct_vld_r <= '0;
    end else if (cmd.commit && is_clear) begin
      ph_vld_r <= '0;
      ct_vld_r <= '0;
    end else begin
      if (ph_we) begin
        ph_vld_r[ph_idx_r] <= 1'b1;
      end
      if (ct_we) begin
        ct_vld_r[ct_idx_r] <= 1'b1;
      end
    end
  end

  // result register
  logic                  out_valid_r, rd_load;
  logic [OUT_DATA_W-1:0] out_data_r, rd_data;

  assign rd_load = cmd.commit && (is_rd_ph || is_rd_ct);

  always_comb begin
    rd_data = '0;
    if (monitor_en_r && is_rd_ph) begin
      rd_data[ROW_W-1:0] = ph_row;
    end else if (monitor_en_r && is_rd_ct) begin
      rd_data[ROW_W +: TIME_W] = ct_cur;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (rd_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_load) begin
      out_data_r <= rd_data;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign out_tdata     = out_data_r;
  assign stat.is_read  = is_rd_ph || is_rd_ct;
  assign stat.out_busy = out_valid_r && !out_tready;

endmodule

// File: rtl/ptsu_checker.sv
// port-level checks of the phase timing statistics unit and their binding
`include "assert_macros.svh"

module ptsu_checker import ptsu_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // no result survives a reset
  `PTSU_ASSERT_ALWAYS(a_rst_no_result, !rst_n |=> !out_tvalid, "result valid after reset")

  // one item at a time: busy in the cycle after a transfer
  `PTSU_ASSERT(a_busy_after_take, in_tvalid && in_tready |=> !in_tready, "ready right after a transfer")

  // the engine only stalls behind a waiting result
  `PTSU_ASSERT(a_stall_cause, !in_tready |=> in_tready || out_tvalid, "stalled with no result pending")

  // a new result comes from the execute cycle
  `PTSU_ASSERT(a_result_source, $rose(out_tvalid) |-> !$past(in_tready), "result without an item in flight")

  // a stalled result holds
  `PTSU_ASSERT(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result changed")

endmodule

bind phase_timing_stats_unit ptsu_checker u_ptsu_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// File: tb/sv/phase_timing_stats_unit_test.sv
// self-checking stream testbench for the phase timing statistics unit
module phase_timing_stats_unit_test;
  import ptsu_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [CFG_ADDR_W-1:0] REG_RUN_ITERATIONS = 1'b1;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int QUIET_FIRST = 1500;
  localparam int QUIET_LAST = 2700;

  // one monitor request as it goes over the input stream
  typedef struct {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [TIME_W-1:0] amount;
  } monitor_req_t;

  // one read response
  typedef struct {
    logic [TIME_W-1:0] sum_ns;
    logic [TIME_W-1:0] samples;
    logic [TIME_W-1:0] lo_ns;
    logic [TIME_W-1:0] hi_ns;
    logic [TIME_W-1:0] events;
  } read_resp_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]       in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  phase_timing_stats_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // shadow copy of the tables and registers
  logic [TIME_W-1:0] phase_sum_ns   [PHASE_SLOTS_DEF];
  logic [TIME_W-1:0] phase_samples  [PHASE_SLOTS_DEF];
  logic [TIME_W-1:0] phase_lo_ns    [PHASE_SLOTS_DEF];
  logic [TIME_W-1:0] phase_hi_ns    [PHASE_SLOTS_DEF];
  logic [TIME_W-1:0] event_totals   [COUNTER_SLOTS_DEF];
  logic              shadow_enable = 1'b0;
  logic [TIME_W-1:0] shadow_iterations = '0;

  monitor_req_t pending_reqs[$];
  read_resp_t   expected_reads[$];
  monitor_req_t active_req;
  int unsigned  cycle_no = 0;
  int unsigned  idle_cycles = 0;
  int           err_count = 0;

  // clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [TIME_W-1:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic logic quiet_window();
    return cycle_no >= QUIET_FIRST && cycle_no < QUIET_LAST;
  endfunction

  function automatic void clear_shadow();
    for (int i = 0; i < PHASE_SLOTS_DEF; i++) begin
      phase_sum_ns[i] = '0;
      phase_samples[i] = '0;
      phase_lo_ns[i] = '0;
      phase_hi_ns[i] = '0;
    end
    for (int i = 0; i < COUNTER_SLOTS_DEF; i++) event_totals[i] = '0;
  endfunction

  // update the shadow tables for one accepted request, queue any read response
  function automatic void apply_request(monitor_req_t r);
    read_resp_t        resp;
    logic [TIME_W-1:0] elapsed;
    int                s;
    s = int'(r.slot);
    case (r.op)
      OP_RECORD: begin
        if (shadow_enable && r.t_start != '0 && s < PHASE_SLOTS_DEF) begin
          // time running backwards counts as a zero-length sample
          elapsed = (r.t_end >= r.t_start) ? r.t_end - r.t_start : '0;
          phase_sum_ns[s] += elapsed;
          phase_samples[s] += TIME_W'(1);
          if (phase_samples[s] == TIME_W'(1) || elapsed < phase_lo_ns[s]) phase_lo_ns[s] = elapsed;
          if (elapsed > phase_hi_ns[s]) phase_hi_ns[s] = elapsed;
        end
      end
      OP_ADD: begin
        if (shadow_enable && s < COUNTER_SLOTS_DEF) begin
          if (TIME_MAX - event_totals[s] < r.amount) event_totals[s] = TIME_MAX;
          else event_totals[s] = event_totals[s] + r.amount;
        end
      end
      OP_READ_PHASE, OP_READ_COUNTER: begin
        resp = '{default: '0};
        if (shadow_enable && r.op == OP_READ_PHASE && s < PHASE_SLOTS_DEF) begin
          resp.sum_ns = phase_sum_ns[s];
          resp.samples = phase_samples[s];
          resp.lo_ns = phase_lo_ns[s];
          resp.hi_ns = phase_hi_ns[s];
        end else if (shadow_enable && r.op == OP_READ_COUNTER && s < COUNTER_SLOTS_DEF) begin
          resp.events = event_totals[s];
        end
        expected_reads.push_back(resp);
      end
      OP_CLEAR: clear_shadow();
      default: ;
    endcase
  endfunction

  function automatic void queue_req(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                                    logic [TIME_W-1:0] t_start, logic [TIME_W-1:0] t_end,
                                    logic [TIME_W-1:0] amount);
    monitor_req_t r;
    r.op = op;
    r.slot = slot;
    r.t_start = t_start;
    r.t_end = t_end;
    r.amount = amount;
    pending_reqs.push_back(r);
  endfunction

  // random request: mostly records and adds on a few hot slots so the stats build up
  function automatic void queue_random_req();
    int unsigned       pick;
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] t_start;
    logic [TIME_W-1:0] t_end;
    logic [TIME_W-1:0] amount;
    pick = $urandom_range(0, 99);
    if (pick < 38) op = OP_RECORD;
    else if (pick < 58) op = OP_ADD;
    else if (pick < 76) op = OP_READ_PHASE;
    else if (pick < 94) op = OP_READ_COUNTER;
    else if (pick < 96) op = OP_CLEAR;
    else op = OP_W'($urandom_range(5, 7));
    slot = ($urandom_range(0, 99) < 70) ? SLOT_W'($urandom_range(0, 7))
                                        : SLOT_W'($urandom_range(0, 63));
    pick = $urandom_range(0, 99);
    if (pick < 8) t_start = '0;
    else if (pick < 13) t_start = TIME_MAX;
    else t_start = rand64();
    pick = $urandom_range(0, 99);
    if (pick < 65) t_end = t_start + $urandom_range(0, 5000);
    else if (pick < 80) t_end = rand64();
    else if (pick < 90) t_end = t_start - $urandom_range(1, 5000);
    else if (pick < 95) t_end = TIME_MAX;
    else t_end = '0;
    pick = $urandom_range(0, 99);
    if (pick < 60) amount = TIME_W'($urandom_range(0, 1000));
    else if (pick < 85) amount = rand64();
    else amount = TIME_MAX - $urandom_range(0, 1000);
    queue_req(op, slot, t_start, t_end, amount);
  endfunction

  // register write while the block is idle
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_MONITOR_ENABLE) shadow_enable = value[0];
    else shadow_iterations = value;
  endtask

  // let every queued request go through and every read come back
  // sampled on the falling edge so the driver's updates have settled
  task automatic wait_drained();
    do begin
      @(negedge clk);
    end while (pending_reqs.size() != 0 || in_tvalid || expected_reads.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random(int count);
    for (int i = 0; i < count; i++) queue_random_req();
    wait_drained();
  endtask

  // input driver
  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_tready) begin
      if (pending_reqs.size() != 0 && (quiet_window() || $urandom_range(0, 99) >= 32)) begin
        active_req <= pending_reqs[0];
        in_tvalid <= 1'b1;
        in_tuser <= pending_reqs[0].op;
        in_tdata <= {2'b00, pending_reqs[0].amount, pending_reqs[0].t_end,
                     pending_reqs[0].t_start, pending_reqs[0].slot};
        void'(pending_reqs.pop_front());
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result back-pressure
  always @(posedge clk) begin
    out_tready <= rst_n && (quiet_window() || $urandom_range(0, 99) >= 32);
  end

  function automatic void check_field(string name, logic [TIME_W-1:0] exp_v,
                                      logic [TIME_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %h, actual %h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // monitor: predict on input transfers, compare on output transfers
  always @(posedge clk) begin
    read_resp_t want;
    if (rst_n && in_tvalid && in_tready) apply_request(active_req);
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_reads.size() == 0) begin
        $error("read response with none outstanding: %h", out_tdata);
        err_count++;
      end else begin
        want = expected_reads.pop_front();
        check_field("total_time", want.sum_ns, out_tdata[63:0]);
        check_field("sample_count", want.samples, out_tdata[127:64]);
        check_field("min_time", want.lo_ns, out_tdata[191:128]);
        check_field("max_time", want.hi_ns, out_tdata[255:192]);
        check_field("event_total", want.events, out_tdata[319:256]);
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    clear_shadow();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // monitor still disabled after reset: updates dropped, reads give zeros
    queue_req(OP_RECORD, 6'd0, 64'd5, 64'd10, '0);
    queue_req(OP_ADD, 6'd0, '0, '0, 64'd3);
    queue_req(OP_READ_PHASE, 6'd0, '0, '0, '0);
    queue_req(OP_READ_COUNTER, 6'd0, '0, '0, '0);
    wait_drained();

    write_reg(REG_MONITOR_ENABLE, 64'd1);
    write_reg(REG_RUN_ITERATIONS, 64'd0);

    // field extremes, backwards time, zero start, out-of-range slots, saturation, unused ops, clear
    queue_req(OP_RECORD, 6'd0, 64'd1, TIME_MAX, '0);
    queue_req(OP_RECORD, 6'd0, TIME_MAX, 64'd0, '0);
    queue_req(OP_RECORD, 6'd0, 64'd0, 64'd100, '0);
    queue_req(OP_RECORD, 6'd0, 64'd7, TIME_MAX, '0);
    queue_req(OP_RECORD, 6'd31, TIME_MAX, TIME_MAX, '0);
    queue_req(OP_RECORD, 6'd32, 64'd1, 64'd50, '0);
    queue_req(OP_RECORD, 6'd63, 64'd1, 64'd50, '0);
    queue_req(OP_READ_PHASE, 6'd0, '0, '0, '0);
    queue_req(OP_READ_PHASE, 6'd31, TIME_MAX, TIME_MAX, TIME_MAX);
    queue_req(OP_READ_PHASE, 6'd32, '0, '0, '0);
    queue_req(OP_READ_PHASE, 6'd63, '0, '0, '0);
    queue_req(OP_ADD, 6'd31, '0, '0, TIME_MAX);
    queue_req(OP_ADD, 6'd31, '0, '0, 64'd1);
    queue_req(OP_ADD, 6'd0, '0, '0, 64'd0);
    queue_req(OP_ADD, 6'd63, '0, '0, 64'd9);
    queue_req(OP_READ_COUNTER, 6'd31, '0, '0, '0);
    queue_req(OP_READ_COUNTER, 6'd0, '0, '0, '0);
    queue_req(OP_READ_COUNTER, 6'd63, '0, '0, '0);
    queue_req(3'd5, 6'd1, rand64(), rand64(), rand64());
    queue_req(3'd6, 6'd2, rand64(), rand64(), rand64());
    queue_req(3'd7, 6'd3, rand64(), rand64(), rand64());
    queue_req(OP_CLEAR, 6'd0, '0, '0, '0);
    queue_req(OP_READ_PHASE, 6'd0, '0, '0, '0);
    queue_req(OP_READ_COUNTER, 6'd31, '0, '0, '0);
    wait_drained();

    // random phases over several register settings
    write_reg(REG_RUN_ITERATIONS, TIME_MAX);
    run_random(400);
    write_reg(REG_MONITOR_ENABLE, 64'd0);
    write_reg(REG_RUN_ITERATIONS, rand64());
    run_random(150);
    write_reg(REG_MONITOR_ENABLE, 64'd1);
    run_random(400);
    write_reg(REG_RUN_ITERATIONS, rand64());
    run_random(400);

    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
